### rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg: shared definitions for the largest label slice area block
// Operation codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package lsa_pkg;

  // Default table geometry
  localparam int LABEL_COUNT_DEFAULT = 65536;
  localparam int COUNT_BITS_DEFAULT  = 24;

  // Fixed field widths
  localparam int TAG_BITS       = 32;
  localparam int LABEL_BITS     = 16;
  localparam int AREA_BITS      = 56;
  localparam int PIXEL_BITS     = 32;
  localparam int FEATURE_BITS   = 17;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [AREA_BITS-1:0]    AREA_MAX            = {AREA_BITS{1'b1}};
  localparam logic [PIXEL_BITS-1:0]   PIXEL_AREA_RESET    = 32'd65536;
  localparam logic [FEATURE_BITS-1:0] FEATURE_COUNT_RESET = 17'd65536;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_AREA    = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEATURE_COUNT = 8'd1;

  // Operation codes
  typedef enum logic [1:0] {
    OP_NEW_VOLUME = 2'd0,
    OP_VOXEL      = 2'd1,
    OP_END_SLICE  = 2'd2,
    OP_READ       = 2'd3
  } op_t;

endpackage

### rtl/lsa_table.sv
// ----------------------------------------------------------------------------
// lsa_table: per-label entry memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module lsa_table #(
  parameter int DEPTH = lsa_pkg::LABEL_COUNT_DEFAULT,
  parameter int WIDTH = lsa_pkg::TAG_BITS + 2 * lsa_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/lsa_entry_update.sv
// ----------------------------------------------------------------------------
// lsa_entry_update: next value of one label entry
// Restarts stale counts, bumps the slice count with saturation, raises the
// running maximum, and tells whether the stored tag is in the current volume.
// ----------------------------------------------------------------------------
module lsa_entry_update #(
  parameter int COUNT_BITS = lsa_pkg::COUNT_BITS_DEFAULT
) (
  input  logic [lsa_pkg::TAG_BITS-1:0] slice_number,
  input  logic [lsa_pkg::TAG_BITS-1:0] volume_first_slice,
  input  logic [lsa_pkg::TAG_BITS-1:0] entry_tag,
  input  logic [COUNT_BITS-1:0]        entry_count,
  input  logic [COUNT_BITS-1:0]        entry_largest,
  output logic                         in_volume,
  output logic [COUNT_BITS-1:0]        new_count,
  output logic [COUNT_BITS-1:0]        new_largest
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [lsa_pkg::TAG_BITS-1:0] tag_offset;
  logic [lsa_pkg::TAG_BITS-1:0] slice_offset;
  logic [COUNT_BITS-1:0]        base_count;
  logic [COUNT_BITS-1:0]        base_largest;

  // Tag lies between the volume's first slice and the current one (mod 2^32)
  assign tag_offset   = entry_tag - volume_first_slice;
  assign slice_offset = slice_number - volume_first_slice;
  assign in_volume    = (tag_offset <= slice_offset);

  // Restart the slice count on a new slice, the maximum on a new volume
  always_comb begin
    base_count   = entry_count;
    base_largest = entry_largest;
    if (entry_tag != slice_number) begin
      base_count = '0;
      if (!in_volume) begin
        base_largest = '0;
      end
    end
    new_count   = (base_count < COUNT_MAX) ? base_count + 1'b1 : base_count;
    new_largest = (new_count > base_largest) ? new_count : base_largest;
  end

endmodule

### rtl/largest_label_slice_area.sv
// ----------------------------------------------------------------------------
// largest_label_slice_area: largest per-slice voxel area of each label
// Table-based tracker of per-slice and maximum voxel counts per label.
// ----------------------------------------------------------------------------
// Each item goes from transfer to result in steps: the label entry is read
// from the table; in S_LOOKUP the entry is modified and written back while
// the largest count is multiplied by pixel_area into a register; in
// S_PRODUCT the product is saturated into the output register, waiting while
// a held result is stalled. Only one item is in flight, so the table never
// sees a read and a write of the same entry overlap. A result waiting in the
// output register does not block the next transfer. After reset the block
// clears the table, one entry per cycle through all LABEL_COUNT entries, and
// holds in_stall high meanwhile; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module largest_label_slice_area #(
  parameter int LABEL_COUNT = lsa_pkg::LABEL_COUNT_DEFAULT,
  parameter int COUNT_BITS  = lsa_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           operation,
  input  logic [lsa_pkg::LABEL_BITS-1:0]       label,
  // Results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lsa_pkg::AREA_BITS-1:0]        largest_area,
  output logic                                 label_error,
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lsa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [lsa_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int ADDR_BITS  = $clog2(LABEL_COUNT);
  localparam int ENTRY_BITS = lsa_pkg::TAG_BITS + 2 * COUNT_BITS;
  localparam int PROD_BITS  = COUNT_BITS + lsa_pkg::PIXEL_BITS;
  localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(LABEL_COUNT - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_PRODUCT
  } state_t;

  state_t state;

  // Configuration and slice state
  logic [lsa_pkg::PIXEL_BITS-1:0]   pixel_area;
  logic [lsa_pkg::FEATURE_BITS-1:0] feature_count;
  logic [lsa_pkg::TAG_BITS-1:0]     slice_number;
  logic [lsa_pkg::TAG_BITS-1:0]     volume_first_slice;

  // Item in flight
  lsa_pkg::op_t                     op_q;
  logic [ADDR_BITS-1:0]             addr_q;
  logic                             err_q;
  logic                             act_q;
  logic [ADDR_BITS-1:0]             clr_addr;
  logic [PROD_BITS-1:0]             product;

  // Table ports
  logic                             tbl_wr_en;
  logic [ADDR_BITS-1:0]             tbl_wr_addr;
  logic [ENTRY_BITS-1:0]            tbl_wr_data;
  logic                             tbl_rd_en;
  logic [ENTRY_BITS-1:0]            tbl_rd_data;

  // Decoded entry and its update
  logic [lsa_pkg::TAG_BITS-1:0]     ent_tag;
  logic [COUNT_BITS-1:0]            ent_count;
  logic [COUNT_BITS-1:0]            ent_largest;
  logic                             ent_in_volume;
  logic [COUNT_BITS-1:0]            new_count;
  logic [COUNT_BITS-1:0]            new_largest;

  // Input decode
  lsa_pkg::op_t                     in_op;
  logic                             in_accept;
  logic                             in_label_ok;
  logic                             in_uses_label;
  logic [ADDR_BITS+lsa_pkg::LABEL_BITS-1:0] label_wide;
  logic [ADDR_BITS-1:0]             in_addr;

  // Product saturation
  logic [63:0]                      product_wide;
  logic                             voxel_write;
  logic [COUNT_BITS-1:0]            mult_count;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_op     = lsa_pkg::op_t'(operation);

  // Label checks against feature_count and table size
  assign label_wide    = {{ADDR_BITS{1'b0}}, label};
  assign in_addr       = label_wide[ADDR_BITS-1:0];
  assign in_uses_label = (in_op == lsa_pkg::OP_VOXEL) || (in_op == lsa_pkg::OP_READ);
  assign in_label_ok   = (32'(label) < 32'(feature_count)) && (32'(label) < 32'(LABEL_COUNT));

  // Entry layout: tag, slice count, largest count
  assign ent_tag     = tbl_rd_data[ENTRY_BITS-1 -: lsa_pkg::TAG_BITS];
  assign ent_count   = tbl_rd_data[2*COUNT_BITS-1 -: COUNT_BITS];
  assign ent_largest = tbl_rd_data[COUNT_BITS-1:0];

  lsa_entry_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .slice_number       (slice_number),
    .volume_first_slice (volume_first_slice),
    .entry_tag          (ent_tag),
    .entry_count        (ent_count),
    .entry_largest      (ent_largest),
    .in_volume          (ent_in_volume),
    .new_count          (new_count),
    .new_largest        (new_largest)
  );

  // Table write: clearing pass or voxel write-back
  assign voxel_write = (state == S_LOOKUP) && act_q && (op_q == lsa_pkg::OP_VOXEL);
  assign tbl_wr_en   = (state == S_CLEAR) || voxel_write;
  assign tbl_wr_addr = (state == S_CLEAR) ? clr_addr : addr_q;
  assign tbl_wr_data = (state == S_CLEAR) ? '0 : {slice_number, new_count, new_largest};
  assign tbl_rd_en   = in_accept;

  lsa_table #(
    .DEPTH (LABEL_COUNT),
    .WIDTH (ENTRY_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (in_addr),
    .rd_data (tbl_rd_data)
  );

  // Multiplier operand: only a read of a live entry gives a nonzero area
  assign mult_count = (act_q && (op_q == lsa_pkg::OP_READ) && ent_in_volume) ?
                      ent_largest : '0;
  assign product_wide = 64'(product);

  // Control, configuration, item and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_CLEAR;
      clr_addr           <= '0;
      pixel_area         <= lsa_pkg::PIXEL_AREA_RESET;
      feature_count      <= lsa_pkg::FEATURE_COUNT_RESET;
      slice_number       <= '0;
      volume_first_slice <= '0;
      out_valid          <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lsa_pkg::REG_PIXEL_AREA) begin
          pixel_area <= cfg_data;
        end else if (cfg_index == lsa_pkg::REG_FEATURE_COUNT) begin
          feature_count <= cfg_data[lsa_pkg::FEATURE_BITS-1:0];
        end
      end

      // Result taken downstream; in S_PRODUCT the next result reloads it
      if (out_valid && !out_stall && (state != S_PRODUCT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            op_q   <= in_op;
            addr_q <= in_addr;
            err_q  <= in_uses_label && !in_label_ok;
            act_q  <= in_uses_label && in_label_ok && (label != '0);
            state  <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          // Slice advances; entry write-back happens on the table port
          if (op_q == lsa_pkg::OP_NEW_VOLUME) begin
            slice_number       <= slice_number + 1'b1;
            volume_first_slice <= slice_number + 1'b1;
          end else if (op_q == lsa_pkg::OP_END_SLICE) begin
            slice_number <= slice_number + 1'b1;
          end
          product <= PROD_BITS'(mult_count) * PROD_BITS'(pixel_area);
          state   <= S_PRODUCT;
        end
        S_PRODUCT: begin
          if (!out_valid || !out_stall) begin
            largest_area <= (product_wide > 64'(lsa_pkg::AREA_MAX)) ?
                            lsa_pkg::AREA_MAX : product_wide[lsa_pkg::AREA_BITS-1:0];
            label_error  <= err_q;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Nothing reaches the output while the table is being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result present during clearing pass");

  // A flagged label never carries an area
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && label_error) |-> (largest_area == '0))
    else $error("label error with nonzero area");

  // Table writes only come from clearing or a voxel write-back
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    tbl_wr_en |-> ((state == S_CLEAR) || (state == S_LOOKUP)))
    else $error("table write outside clear or lookup");

  // A transfer is followed by the table lookup cycle
  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_LOOKUP))
    else $error("transfer not followed by lookup");

endmodule
